// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of the complex arithmetic unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CAU_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define CAU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CAU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/cau_pkg.sv -----
// Package: constants, operation codes and defaults of the complex arithmetic unit.
`default_nettype none

package cau_pkg;

    localparam int FRAC_BITS_DEF  = 12;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int OP_WIDTH       = 3;

    // Value returned for both parts on a zero divisor, before scaling.
    localparam longint unsigned DIVZERO_VALUE = 64'd99999;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4,
        OP_NE  = 3'd5
    } t_op;

endpackage

`default_nettype wire

// ----- hdl/cau_if.sv -----
// Valid/ready channel interfaces for operand and result transactions.
`default_nettype none

interface cau_in_if #(
    parameter int DW = cau_pkg::DATA_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [cau_pkg::OP_WIDTH-1:0]  operation;
    logic signed [DW-1:0]          a_real;
    logic signed [DW-1:0]          a_imag;
    logic signed [DW-1:0]          b_real;
    logic signed [DW-1:0]          b_imag;

    modport source (output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
    modport sink   (input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if #(
    parameter int DW = cau_pkg::DATA_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic signed [DW-1:0]  res_real;
    logic signed [DW-1:0]  res_imag;
    logic                  truth;
    logic                  divide_by_zero;
    logic                  saturated;

    modport source (output valid, res_real, res_imag, truth, divide_by_zero, saturated,
                    input ready);
    modport sink   (input valid, res_real, res_imag, truth, divide_by_zero, saturated,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/cau_divider.sv -----
// Pipelined restoring divider, two numerator lanes sharing one divisor, one bit a stage.
`default_nettype none

module cau_divider #(
    parameter int DW = cau_pkg::DATA_WIDTH_DEF,
    parameter int FB = cau_pkg::FRAC_BITS_DEF,
    parameter int SW = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [2*DW-1:0]  i_mag_re,
    input  wire logic [2*DW-1:0]  i_mag_im,
    input  wire logic [2*DW-1:0]  i_den,
    input  wire logic [SW-1:0]    i_side,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [DW-1:0]         o_q_re,
    output logic [DW-1:0]         o_q_im,
    output logic                  o_ovf_re,
    output logic                  o_ovf_im,
    output logic [SW-1:0]         o_side
);

    localparam int PW = 2 * DW;                  // divisor width
    localparam int NW = PW + FB;                 // scaled numerator width
    localparam int CW = (NW > 3 * DW) ? NW : 3 * DW;
    localparam int RW = PW + 1;                  // partial remainder width

    // Stage 0 loads, stages 1..DW each resolve one quotient bit
    logic             r_v       [0:DW];
    logic [RW-1:0]    r_rem_re  [0:DW];
    logic [RW-1:0]    r_rem_im  [0:DW];
    logic [DW-1:0]    r_low_re  [0:DW];
    logic [DW-1:0]    r_low_im  [0:DW];
    logic [DW-1:0]    r_q_re    [0:DW];
    logic [DW-1:0]    r_q_im    [0:DW];
    logic             r_ovf_re  [0:DW];
    logic             r_ovf_im  [0:DW];
    logic [PW-1:0]    r_den     [0:DW];
    logic [SW-1:0]    r_side    [0:DW];

    logic [DW:0]      w_en;

    logic [RW-1:0]    n_rem_re  [1:DW];
    logic [RW-1:0]    n_rem_im  [1:DW];
    logic [DW-1:0]    n_q_re    [1:DW];
    logic [DW-1:0]    n_q_im    [1:DW];

    logic [NW-1:0]    w_n_re;
    logic [NW-1:0]    w_n_im;
    logic [CW-1:0]    w_den_hi;
    logic             w_ovf_re;
    logic             w_ovf_im;

    // Stall chain: a stage moves when it is empty or the next one moves
    assign w_en[DW] = ~r_v[DW] | i_ready;
    for (genvar g = 0; g < DW; g++) begin : g_en
        assign w_en[g] = ~r_v[g] | w_en[g+1];
    end
    assign o_ready = w_en[0];

    // Entry: scale numerators, flag quotients that cannot fit in DW bits
    assign w_n_re   = NW'(i_mag_re) << FB;
    assign w_n_im   = NW'(i_mag_im) << FB;
    assign w_den_hi = CW'(i_den) << DW;
    assign w_ovf_re = CW'(w_n_re) >= w_den_hi;
    assign w_ovf_im = CW'(w_n_im) >= w_den_hi;

    // One compare and subtract per stage and lane
    always_comb begin
        logic [RW-1:0] t_re;
        logic [RW-1:0] t_im;
        logic          ge_re;
        logic          ge_im;
        for (int i = 1; i <= DW; i++) begin
            t_re  = {r_rem_re[i-1][RW-2:0], r_low_re[i-1][DW-1]};
            t_im  = {r_rem_im[i-1][RW-2:0], r_low_im[i-1][DW-1]};
            ge_re = t_re >= {1'b0, r_den[i-1]};
            ge_im = t_im >= {1'b0, r_den[i-1]};
            n_rem_re[i] = ge_re ? t_re - {1'b0, r_den[i-1]} : t_re;
            n_rem_im[i] = ge_im ? t_im - {1'b0, r_den[i-1]} : t_im;
            n_q_re[i]   = {r_q_re[i-1][DW-2:0], ge_re};
            n_q_im[i]   = {r_q_im[i-1][DW-2:0], ge_im};
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= DW; i++) r_v[i] <= 1'b0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int i = 1; i <= DW; i++) begin
                if (w_en[i]) r_v[i] <= r_v[i-1];
            end
        end
    end

    // Stage data
    always_ff @(posedge i_clk) begin
        if (w_en[0] && i_valid) begin
            r_rem_re[0] <= RW'(w_n_re >> DW);
            r_rem_im[0] <= RW'(w_n_im >> DW);
            r_low_re[0] <= w_n_re[DW-1:0];
            r_low_im[0] <= w_n_im[DW-1:0];
            r_q_re[0]   <= '0;
            r_q_im[0]   <= '0;
            r_ovf_re[0] <= w_ovf_re;
            r_ovf_im[0] <= w_ovf_im;
            r_den[0]    <= i_den;
            r_side[0]   <= i_side;
        end
        for (int i = 1; i <= DW; i++) begin
            if (w_en[i] && r_v[i-1]) begin
                r_rem_re[i] <= n_rem_re[i];
                r_rem_im[i] <= n_rem_im[i];
                r_low_re[i] <= r_low_re[i-1] << 1;
                r_low_im[i] <= r_low_im[i-1] << 1;
                r_q_re[i]   <= n_q_re[i];
                r_q_im[i]   <= n_q_im[i];
                r_ovf_re[i] <= r_ovf_re[i-1];
                r_ovf_im[i] <= r_ovf_im[i-1];
                r_den[i]    <= r_den[i-1];
                r_side[i]   <= r_side[i-1];
            end
        end
    end

    assign o_valid  = r_v[DW];
    assign o_q_re   = r_q_re[DW];
    assign o_q_im   = r_q_im[DW];
    assign o_ovf_re = r_ovf_re[DW];
    assign o_ovf_im = r_ovf_im[DW];
    assign o_side   = r_side[DW];

endmodule

`default_nettype wire

// ----- hdl/complex_arith_unit.sv -----
// A transaction passes the operand stages, the divider stages and the output register before its result is valid.
// Throughput: one transaction per cycle; the operand pipeline and the bit-per-stage divider
// hold one transaction in every stage and each stage moves whenever the next has room.
// A stalled result holds in the output register while bubbles upstream keep filling.
// Reset is synchronous, active low, and clears every stage valid bit; data is not reset.
`default_nettype none

module complex_arith_unit #(
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cau_in_if.sink     i_in,
    cau_out_if.source  o_out
);

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int PW = 2 * DW;
    localparam int SW = 2 * DW + 6;

    localparam logic [PW-1:0] LIM_POS = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [PW-1:0] LIM_NEG = LIM_POS + PW'(1);
    localparam logic [DW-1:0] MAX_DW  = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MIN_DW  = {1'b1, {(DW-1){1'b0}}};

    // Zero divisor value, scaled and clipped at elaboration
    localparam logic [63:0] DZ_FULL = 64'(cau_pkg::DIVZERO_VALUE) << FB;
    localparam logic        DZ_SAT  = DZ_FULL > ((64'd1 << (DW - 1)) - 64'd1);
    localparam logic [DW-1:0] DZ_VAL = DZ_SAT ? MAX_DW : DZ_FULL[DW-1:0];

    // ---------------- stage 1: operand register
    logic                          r_v1;
    logic [cau_pkg::OP_WIDTH-1:0]  r_op1;
    logic signed [DW-1:0]          r_ar1, r_ai1, r_br1, r_bi1;

    // ---------------- stage 2: products, add/sub, compare
    logic                          r_v2;
    logic [cau_pkg::OP_WIDTH-1:0]  r_op2;
    logic signed [PW-1:0]          r_p_arbr, r_p_aibi, r_p_arbi, r_p_aibr, r_p_brbr, r_p_bibi;
    logic [DW-1:0]                 r_as_re2, r_as_im2;
    logic                          r_as_sat2, r_truth2, r_dz2;

    // ---------------- stage 3: sums of products
    logic                          r_v3;
    logic [cau_pkg::OP_WIDTH-1:0]  r_op3;
    logic signed [PW:0]            r_re_sum, r_im_sum;
    logic [PW-1:0]                 r_den3;
    logic [DW-1:0]                 r_as_re3, r_as_im3;
    logic                          r_as_sat3, r_truth3, r_dz3;

    // ---------------- stage 4: sign and magnitude
    logic                          r_v4;
    logic [cau_pkg::OP_WIDTH-1:0]  r_op4;
    logic [PW-1:0]                 r_mag_re4, r_mag_im4, r_den4;
    logic                          r_neg_re4, r_neg_im4;
    logic [DW-1:0]                 r_as_re4, r_as_im4;
    logic                          r_as_sat4, r_truth4, r_dz4;

    // ---------------- stage 5: non-divide results settled
    logic                          r_v5;
    logic [PW-1:0]                 r_mag_re5, r_mag_im5, r_den5;
    logic [SW-1:0]                 r_side5;

    // ---------------- output register
    logic                          r_ov;
    logic signed [DW-1:0]          r_res_re, r_res_im;
    logic                          r_truth_o, r_dz_o, r_sat_o;

    logic w_en1, w_en2, w_en3, w_en4, w_en5, w_en_o;
    logic w_div_ready, w_div_valid;

    // Stall chain
    assign w_en_o = ~r_ov | o_out.ready;
    assign w_en5  = ~r_v5 | w_div_ready;
    assign w_en4  = ~r_v4 | w_en5;
    assign w_en3  = ~r_v3 | w_en4;
    assign w_en2  = ~r_v2 | w_en3;
    assign w_en1  = ~r_v1 | w_en2;
    assign i_in.ready = w_en1;

    // Stage 2 logic
    logic signed [PW-1:0] w_p_arbr, w_p_aibi, w_p_arbi, w_p_aibr, w_p_brbr, w_p_bibi;
    logic [DW:0]          w_as_re, w_as_im;
    logic                 w_same;
    logic                 w_truth;

    assign w_p_arbr = r_ar1 * r_br1;
    assign w_p_aibi = r_ai1 * r_bi1;
    assign w_p_arbi = r_ar1 * r_bi1;
    assign w_p_aibr = r_ai1 * r_br1;
    assign w_p_brbr = r_br1 * r_br1;
    assign w_p_bibi = r_bi1 * r_bi1;

    assign w_as_re = (r_op1 == cau_pkg::OP_SUB) ? {r_ar1[DW-1], r_ar1} - {r_br1[DW-1], r_br1}
                                                : {r_ar1[DW-1], r_ar1} + {r_br1[DW-1], r_br1};
    assign w_as_im = (r_op1 == cau_pkg::OP_SUB) ? {r_ai1[DW-1], r_ai1} - {r_bi1[DW-1], r_bi1}
                                                : {r_ai1[DW-1], r_ai1} + {r_bi1[DW-1], r_bi1};

    assign w_same  = (r_ar1 == r_br1) && (r_ai1 == r_bi1);
    assign w_truth = ((r_op1 == cau_pkg::OP_EQ) && w_same) ||
                     ((r_op1 == cau_pkg::OP_NE) && !w_same);

    // Stage 3 logic: multiply and divide numerators share the four cross products
    logic                 w_is_mul3;
    logic signed [PW:0]   w_re_sum, w_im_sum;
    logic [PW-1:0]        w_den;

    assign w_is_mul3 = (r_op2 == cau_pkg::OP_MUL);
    assign w_re_sum  = w_is_mul3 ? r_p_arbr - r_p_aibi : r_p_arbr + r_p_aibi;
    assign w_im_sum  = w_is_mul3 ? r_p_arbi + r_p_aibr : r_p_aibr - r_p_arbi;
    assign w_den     = $unsigned(r_p_brbr) + $unsigned(r_p_bibi);

    // Stage 4 logic
    logic signed [PW:0] w_neg_re, w_neg_im;
    assign w_neg_re = -r_re_sum;
    assign w_neg_im = -r_im_sum;

    // Stage 5 logic: product truncation toward zero and clipping
    logic [PW-1:0] w_t_re, w_t_im, w_lim_re, w_lim_im, w_m_re, w_m_im;
    logic          w_ms_re, w_ms_im;
    logic [DW-1:0] w_mul_re, w_mul_im;
    logic [DW-1:0] w_fin_re, w_fin_im;
    logic          w_fin_sat;

    assign w_t_re   = r_mag_re4 >> FB;
    assign w_t_im   = r_mag_im4 >> FB;
    assign w_lim_re = r_neg_re4 ? LIM_NEG : LIM_POS;
    assign w_lim_im = r_neg_im4 ? LIM_NEG : LIM_POS;
    assign w_ms_re  = w_t_re > w_lim_re;
    assign w_ms_im  = w_t_im > w_lim_im;
    assign w_m_re   = w_ms_re ? w_lim_re : w_t_re;
    assign w_m_im   = w_ms_im ? w_lim_im : w_t_im;
    assign w_mul_re = r_neg_re4 ? -w_m_re[DW-1:0] : w_m_re[DW-1:0];
    assign w_mul_im = r_neg_im4 ? -w_m_im[DW-1:0] : w_m_im[DW-1:0];

    always_comb begin
        w_fin_re  = '0;
        w_fin_im  = '0;
        w_fin_sat = 1'b0;
        case (r_op4) inside
            cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
                w_fin_re  = r_as_re4;
                w_fin_im  = r_as_im4;
                w_fin_sat = r_as_sat4;
            end
            cau_pkg::OP_MUL: begin
                w_fin_re  = w_mul_re;
                w_fin_im  = w_mul_im;
                w_fin_sat = w_ms_re | w_ms_im;
            end
            default: begin
                w_fin_re  = '0;
                w_fin_im  = '0;
                w_fin_sat = 1'b0;
            end
        endcase
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_en1)  r_v1 <= i_in.valid;
            if (w_en2)  r_v2 <= r_v1;
            if (w_en3)  r_v3 <= r_v2;
            if (w_en4)  r_v4 <= r_v3;
            if (w_en5)  r_v5 <= r_v4;
            if (w_en_o) r_ov <= w_div_valid;
        end
    end

    // Pipeline data, stages 1 to 5
    always_ff @(posedge i_clk) begin
        if (w_en1 && i_in.valid) begin
            r_op1 <= i_in.operation;
            r_ar1 <= i_in.a_real;
            r_ai1 <= i_in.a_imag;
            r_br1 <= i_in.b_real;
            r_bi1 <= i_in.b_imag;
        end
        if (w_en2 && r_v1) begin
            r_op2     <= r_op1;
            r_p_arbr  <= w_p_arbr;
            r_p_aibi  <= w_p_aibi;
            r_p_arbi  <= w_p_arbi;
            r_p_aibr  <= w_p_aibr;
            r_p_brbr  <= w_p_brbr;
            r_p_bibi  <= w_p_bibi;
            r_as_re2  <= (w_as_re[DW] != w_as_re[DW-1]) ? (w_as_re[DW] ? MIN_DW : MAX_DW)
                                                        : w_as_re[DW-1:0];
            r_as_im2  <= (w_as_im[DW] != w_as_im[DW-1]) ? (w_as_im[DW] ? MIN_DW : MAX_DW)
                                                        : w_as_im[DW-1:0];
            r_as_sat2 <= (w_as_re[DW] != w_as_re[DW-1]) || (w_as_im[DW] != w_as_im[DW-1]);
            r_truth2  <= w_truth;
            r_dz2     <= (r_op1 == cau_pkg::OP_DIV) && (r_br1 == '0) && (r_bi1 == '0);
        end
        if (w_en3 && r_v2) begin
            r_op3     <= r_op2;
            r_re_sum  <= w_re_sum;
            r_im_sum  <= w_im_sum;
            r_den3    <= w_den;
            r_as_re3  <= r_as_re2;
            r_as_im3  <= r_as_im2;
            r_as_sat3 <= r_as_sat2;
            r_truth3  <= r_truth2;
            r_dz3     <= r_dz2;
        end
        if (w_en4 && r_v3) begin
            r_op4     <= r_op3;
            r_mag_re4 <= r_re_sum[PW] ? w_neg_re[PW-1:0] : r_re_sum[PW-1:0];
            r_mag_im4 <= r_im_sum[PW] ? w_neg_im[PW-1:0] : r_im_sum[PW-1:0];
            r_neg_re4 <= r_re_sum[PW];
            r_neg_im4 <= r_im_sum[PW];
            r_den4    <= r_den3;
            r_as_re4  <= r_as_re3;
            r_as_im4  <= r_as_im3;
            r_as_sat4 <= r_as_sat3;
            r_truth4  <= r_truth3;
            r_dz4     <= r_dz3;
        end
        if (w_en5 && r_v4) begin
            r_mag_re5 <= r_mag_re4;
            r_mag_im5 <= r_mag_im4;
            r_den5    <= r_den4;
            r_side5   <= {(r_op4 == cau_pkg::OP_DIV), r_dz4, w_fin_re, w_fin_im, w_fin_sat,
                          r_truth4, r_neg_re4, r_neg_im4};
        end
    end

    // Divider
    logic [DW-1:0] w_q_re, w_q_im;
    logic          w_ovf_re, w_ovf_im;
    logic [SW-1:0] w_side;

    cau_divider #(
        .DW (DW),
        .FB (FB),
        .SW (SW)
    ) u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v5),
        .o_ready  (w_div_ready),
        .i_mag_re (r_mag_re5),
        .i_mag_im (r_mag_im5),
        .i_den    (r_den5),
        .i_side   (r_side5),
        .o_valid  (w_div_valid),
        .i_ready  (w_en_o),
        .o_q_re   (w_q_re),
        .o_q_im   (w_q_im),
        .o_ovf_re (w_ovf_re),
        .o_ovf_im (w_ovf_im),
        .o_side   (w_side)
    );

    // Final selection: quotient clipping and sign, zero-divisor override
    logic          s_is_div, s_dz, s_fin_sat, s_truth, s_neg_re, s_neg_im;
    logic [DW-1:0] s_fin_re, s_fin_im;
    logic [DW:0]   w_qlim_re, w_qlim_im;
    logic          w_qs_re, w_qs_im;
    logic [DW-1:0] w_qm_re, w_qm_im;

    assign {s_is_div, s_dz, s_fin_re, s_fin_im, s_fin_sat, s_truth, s_neg_re, s_neg_im} = w_side;

    assign w_qlim_re = s_neg_re ? LIM_NEG[DW:0] : LIM_POS[DW:0];
    assign w_qlim_im = s_neg_im ? LIM_NEG[DW:0] : LIM_POS[DW:0];
    assign w_qs_re   = w_ovf_re || ({1'b0, w_q_re} > w_qlim_re);
    assign w_qs_im   = w_ovf_im || ({1'b0, w_q_im} > w_qlim_im);
    assign w_qm_re   = w_qs_re ? w_qlim_re[DW-1:0] : w_q_re;
    assign w_qm_im   = w_qs_im ? w_qlim_im[DW-1:0] : w_q_im;

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_en_o && w_div_valid) begin
            r_truth_o <= s_truth;
            r_dz_o    <= s_dz;
            if (s_is_div && s_dz) begin
                r_res_re <= DZ_VAL;
                r_res_im <= DZ_VAL;
                r_sat_o  <= DZ_SAT;
            end else if (s_is_div) begin
                r_res_re <= s_neg_re ? -w_qm_re : w_qm_re;
                r_res_im <= s_neg_im ? -w_qm_im : w_qm_im;
                r_sat_o  <= w_qs_re | w_qs_im;
            end else begin
                r_res_re <= s_fin_re;
                r_res_im <= s_fin_im;
                r_sat_o  <= s_fin_sat;
            end
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.res_real       = r_res_re;
    assign o_out.res_imag       = r_res_im;
    assign o_out.truth          = r_truth_o;
    assign o_out.divide_by_zero = r_dz_o;
    assign o_out.saturated      = r_sat_o;

endmodule

`default_nettype wire

// ----- hdl/cau_checker.sv -----
// Port-level checker for the complex arithmetic unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module cau_checker #(
    parameter int DW = cau_pkg::DATA_WIDTH_DEF
) (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_out_valid,
    input wire logic          i_out_ready,
    input wire logic [DW-1:0] i_res_real,
    input wire logic [DW-1:0] i_res_imag,
    input wire logic          i_truth,
    input wire logic          i_dz
);

    // A compare result never also reports a zero divisor
    `CAU_ASSERT_IMP(a_flags_exclusive, i_out_valid, !(i_truth && i_dz), "truth with divide_by_zero")

    // Zero-divisor transactions carry equal parts
    `CAU_ASSERT_IMP(a_dz_parts, i_out_valid && i_dz, i_res_real == i_res_imag, "zero divisor parts differ")

    // A true compare returns zero parts
    `CAU_ASSERT_IMP(a_truth_zero, i_out_valid && i_truth, (i_res_real == '0) && (i_res_imag == '0), "compare result not zero")

    // A stalled result stays offered
    `CAU_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    // Nothing is offered in the cycle after reset
    `CAU_ASSERT_IMP(a_reset_empty, !$past(i_rst_n), !i_out_valid, "result valid after reset")

endmodule

bind complex_arith_unit cau_checker #(
    .DW (DATA_WIDTH)
) u_cau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_res_real  (o_out.res_real),
    .i_res_imag  (o_out.res_imag),
    .i_truth     (o_out.truth),
    .i_dz        (o_out.divide_by_zero)
);

`default_nettype wire
